// ===== hw/rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_cmp, skt_mem and sorted_key_table; depends on nothing.
`default_nettype none
package skt_pkg;

	localparam int SKT_DEPTH     = 16;
	localparam int KEY_W         = 32;
	localparam int OPCODE_W      = 2;
	localparam int STATUS_W      = 3;
	localparam int COUNT_W       = 5;
	localparam int S_TDATA_W     = 40;
	localparam int M_TDATA_W     = 48;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_LISTED    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_EMIT,
		S_LIST_RD,
		S_LIST_EMIT
	} state_t;

	// Result of the shared key comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage : skt_pkg
`default_nettype wire

// ===== hw/rtl/skt_cmp.sv =====
// Shared key comparator: stored key against the key of the transaction.
// Depends on skt_pkg.
`default_nettype none
module skt_cmp (
	input  wire logic [skt_pkg::KEY_W-1:0] stored,
	input  wire logic [skt_pkg::KEY_W-1:0] probe,
	output skt_pkg::cmp_res_t              res
);
	import skt_pkg::*;

	// Unsigned magnitude compare
	always_comb begin
		res.lt = (stored < probe);
		res.eq = (stored == probe);
	end

endmodule : skt_cmp
`default_nettype wire

// ===== hw/rtl/skt_mem.sv =====
// Key store: one write port, one read port with registered read data.
// Depends on skt_pkg.
`default_nettype none
module skt_mem #(
	parameter int DEPTH = skt_pkg::SKT_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [skt_pkg::KEY_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic      [skt_pkg::KEY_W-1:0] rdata
);
	import skt_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : skt_mem
`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table: holds up to DEPTH unique 32-bit keys in ascending order in a
// single-port-per-direction memory and takes insert, remove and list commands one
// at a time. Every step goes through that one memory and one shared comparator. An
// insert or remove scans the keys below its key and, where it changes the table,
// moves the keys above it, with one read and one write per key. A listing reads
// and emits each stored key in turn. s_tready is high whenever no command is in
// work; a finished result may wait in the output register while the next command
// is taken. No clearing pass is needed after reset.
// Depends on skt_pkg, skt_cmp and skt_mem.
`default_nettype none
module sorted_key_table #(
	parameter int DEPTH = skt_pkg::SKT_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// fields from bit 0: opcode[1:0], key[33:2], zero pad
	input  wire logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// fields from bit 0: status[2:0], entry_key[34:3], entry_valid[35],
	// count[40:36], zero pad
	output logic      [skt_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                               m_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready
);
	import skt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Sequencer state
	state_t           state_q, state_d;
	opcode_t          op_q, op_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [CW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    sh_q, sh_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             eq_q, eq_d;
	status_t          st_q, st_d;

	// Result register
	logic             m_valid_q;
	status_t          o_status_q;
	logic [KEY_W-1:0] o_key_q;
	logic             o_valid_q;
	logic             o_last_q;
	logic [CW-1:0]    o_cnt_q;
	logic             load;
	logic             o_valid_d;
	logic             o_last_d;
	status_t          o_status_d;
	logic [KEY_W-1:0] o_key_d;
	logic             out_free;

	// Memory and comparator
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [KEY_W-1:0] mem_wdata, mem_rdata;
	cmp_res_t         cmp;

	logic [CW+COUNT_W-1:0] cnt_ext;

	skt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	skt_cmp u_cmp (
		.stored (mem_rdata),
		.probe  (key_q),
		.res    (cmp)
	);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// Next state, memory control and result loading
	always_comb begin
		logic [CW-1:0] sh_prev;
		logic [CW-1:0] sh_next;
		logic [CW-1:0] idx_next;
		sh_prev    = sh_q - CW'(1);
		sh_next    = sh_q + CW'(1);
		idx_next   = idx_q + CW'(1);
		state_d    = state_q;
		op_d       = op_q;
		key_d      = key_q;
		idx_d      = idx_q;
		sh_d       = sh_q;
		cnt_d      = cnt_q;
		eq_d       = eq_q;
		st_d       = st_q;
		mem_we     = 1'b0;
		mem_waddr  = sh_q[AW-1:0];
		mem_wdata  = mem_rdata;
		mem_re     = 1'b0;
		mem_raddr  = idx_q[AW-1:0];
		load       = 1'b0;
		o_status_d = st_q;
		o_key_d    = key_q;
		o_valid_d  = 1'b0;
		o_last_d   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					op_d  = opcode_t'(s_tdata[OPCODE_W-1:0]);
					key_d = s_tdata[OPCODE_W +: KEY_W];
					idx_d = '0;
					case (s_tdata[OPCODE_W-1:0])
						OP_INSERT, OP_REMOVE: state_d = S_SRCH_RD;
						OP_LIST: begin
							if (cnt_q == '0) begin
								key_d   = '0;
								st_d    = ST_LISTED;
								state_d = S_EMIT;
							end else begin
								state_d = S_LIST_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			// Linear search for the first key not below the probe
			S_SRCH_RD: begin
				if (idx_q == cnt_q) begin
					eq_d    = 1'b0;
					state_d = S_DECIDE;
				end else begin
					mem_re  = 1'b1;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (cmp.lt) begin
					idx_d   = idx_next;
					state_d = S_SRCH_RD;
				end else begin
					eq_d    = cmp.eq;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (op_q == OP_INSERT) begin
					if (eq_q) begin
						st_d    = ST_DUPLICATE;
						state_d = S_EMIT;
					end else if (cnt_q == CW'(DEPTH)) begin
						st_d    = ST_FULL;
						state_d = S_EMIT;
					end else begin
						sh_d    = cnt_q;
						state_d = (cnt_q == idx_q) ? S_INS_WR : S_SHIFT_RD;
					end
				end else begin
					if (!eq_q) begin
						st_d    = ST_NOTFOUND;
						state_d = S_EMIT;
					end else if (idx_next >= cnt_q) begin
						cnt_d   = cnt_q - CW'(1);
						st_d    = ST_REMOVED;
						state_d = S_EMIT;
					end else begin
						sh_d    = idx_q;
						state_d = S_SHIFT_RD;
					end
				end
			end
			// Move one entry of the tail: up for insert, down for remove
			S_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = (op_q == OP_INSERT) ? sh_prev[AW-1:0] : sh_next[AW-1:0];
				state_d   = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
				if (op_q == OP_INSERT) begin
					sh_d    = sh_prev;
					state_d = (sh_prev == idx_q) ? S_INS_WR : S_SHIFT_RD;
				end else begin
					sh_d = sh_next;
					if ((sh_next + CW'(1)) >= cnt_q) begin
						cnt_d   = cnt_q - CW'(1);
						st_d    = ST_REMOVED;
						state_d = S_EMIT;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = key_q;
				cnt_d     = cnt_q + CW'(1);
				st_d      = ST_INSERTED;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			// Listing: one read, one result per stored key
			S_LIST_RD: begin
				mem_re  = 1'b1;
				state_d = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				o_status_d = ST_LISTED;
				o_key_d    = mem_rdata;
				o_valid_d  = 1'b1;
				o_last_d   = (idx_next == cnt_q);
				if (out_free) begin
					load  = 1'b1;
					idx_d = idx_next;
					state_d = (idx_next == cnt_q) ? S_IDLE : S_LIST_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload registers
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		idx_q <= idx_d;
		sh_q  <= sh_d;
		eq_q  <= eq_d;
		st_q  <= st_d;
		if (load) begin
			o_status_q <= o_status_d;
			o_key_q    <= o_key_d;
			o_valid_q  <= o_valid_d;
			o_last_q   <= o_last_d;
			o_cnt_q    <= cnt_q;
		end
	end

	// Output packing; count is reported modulo 32
	assign cnt_ext  = {{COUNT_W{1'b0}}, o_cnt_q};
	assign m_tvalid = m_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {(M_TDATA_W - STATUS_W - KEY_W - 1 - COUNT_W)'(0),
		cnt_ext[COUNT_W-1:0], o_valid_q, o_key_q, o_status_q};

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stored key count above DEPTH");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory written while idle");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && o_status_q == ST_INSERTED) |-> (o_cnt_q != '0))
		else $error("insert reported with empty table");

	a_list_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == S_LIST_EMIT && o_last_d) |=> (state_q == S_IDLE))
		else $error("listing did not end after last entry");
`endif

endmodule : sorted_key_table
`default_nettype wire
